### sv/asfc_pkg.sv
// Shared types, format codes and helper functions for the audio sample
// format converter. No dependencies; compiled before every other file.
`default_nettype none

package asfc_pkg;

  // Sample format codes as stored in the format registers
  typedef logic [2:0] fmt_t;

  localparam fmt_t FMT_U8  = 3'd0;
  localparam fmt_t FMT_S16 = 3'd1;
  localparam fmt_t FMT_S32 = 3'd2;
  localparam fmt_t FMT_FLT = 3'd3;
  localparam fmt_t FMT_DBL = 3'd4;

  // Register index decoded from the configuration address
  localparam logic REG_IN_FMT  = 1'b0;
  localparam logic REG_OUT_FMT = 1'b1;

  // Classes of an unpacked sample
  typedef enum logic [1:0] {
    CLS_ZERO,
    CLS_NUM,
    CLS_INF,
    CLS_NAN
  } cls_t;

  // Format settings handed from the register file to the datapath
  typedef struct packed {
    fmt_t in_fmt;
    fmt_t out_fmt;
  } fmt_cfg_t;

  // Unpacked sample: value = sign * 1.frac * 2^expo for CLS_NUM;
  // ival holds the signed integer value of integer inputs
  typedef struct packed {
    cls_t               cls;
    logic               sign;
    logic signed [12:0] expo;
    logic [51:0]        frac;
    logic signed [32:0] ival;
  } unp_t;

  // Leading zero count of a 32-bit word (31 for a zero word)
  function automatic logic [4:0] lzc32(input logic [31:0] w);
    logic [4:0] lz;
    lz = 5'd31;
    for (int i = 0; i < 32; i++) begin
      if (w[i]) begin
        lz = 5'(31 - i);
      end
    end
    return lz;
  endfunction

  // Integer width minus one: 7, 15 or 31
  function automatic logic [4:0] int_wm1(input fmt_t f);
    case (f)
      FMT_U8:  return 5'd7;
      FMT_S16: return 5'd15;
      default: return 5'd31;
    endcase
  endfunction

  // Used-bit mask of a format
  function automatic logic [63:0] fmt_mask(input fmt_t f);
    case (f)
      FMT_U8:  return 64'h0000_0000_0000_00ff;
      FMT_S16: return 64'h0000_0000_0000_ffff;
      FMT_DBL: return 64'hffff_ffff_ffff_ffff;
      default: return 64'h0000_0000_ffff_ffff;
    endcase
  endfunction

  // Pack a signed integer value into an integer format's bits
  function automatic logic [63:0] int_pack(input fmt_t f, input logic [31:0] v);
    case (f)
      FMT_U8:  return {56'd0, v[7:0] + 8'h80};
      FMT_S16: return {48'd0, v[15:0]};
      default: return {32'd0, v};
    endcase
  endfunction

endpackage

`default_nettype wire

### sv/asfc_in_if.sv
// Input sample channel: valid/ready handshake carrying one raw sample word.
// Depends on nothing.
`default_nettype none

interface asfc_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

`default_nettype wire

### sv/asfc_out_if.sv
// Result sample channel: valid/ready handshake carrying one converted word.
// Depends on nothing.
`default_nettype none

interface asfc_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

### sv/audio_sample_format_converter_unit.sv
// Audio sample format converter: u8 / s16 / s32 / float / double.
// Usage:
//   Program in_format (byte address 0) and out_format (address 4) over the
//   APB-style port while no word is in flight; codes 0 u8, 1 s16, 2 s32,
//   3 float, 4 double. Codes 5 to 7 give a zero result.
//   Send raw sample words on in_ch; converted words leave on out_ch, bits
//   above the output width at zero. Each word gives exactly one result.
// Timing:
//   A word accepted at one clock edge is registered, converted by one pass
//   of combinational logic and registered again, then offered on out_ch.
//   One word per cycle is sustained while out_ch.ready holds high; the
//   rate is set by the two-register pipeline, input register then result
//   register, each of which advances whenever the stage after it can take.
// Reset:
//   rst_n low at a clock edge empties both registers and sets both formats
//   to u8. While out_ch.ready is low the result holds, the input register
//   fills, and in_ch.ready drops once both stages hold words.
// Depends on asfc_pkg, asfc_in_if, asfc_out_if, asfc_cfg, asfc_unpack,
// asfc_pack.
`default_nettype none

module audio_sample_format_converter_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  asfc_in_if.sink          in_ch,
  asfc_out_if.source       out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  asfc_pkg::fmt_cfg_t cfg;
  asfc_pkg::unp_t     unp;
  logic               s1_vld_r;
  logic [63:0]        s1_data_r;
  logic               out_vld_r;
  logic [63:0]        out_data_r;
  logic [63:0]        conv;
  logic               s2_load;
  logic               s1_load;

  asfc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  asfc_unpack u_unpack (
    .fi  (cfg.in_fmt),
    .raw (s1_data_r),
    .unp (unp)
  );

  asfc_pack u_pack (
    .cfg (cfg),
    .raw (s1_data_r),
    .unp (unp),
    .res (conv)
  );

  // Advance each stage when the one after it has room
  assign s2_load     = !out_vld_r || out_ch.ready;
  assign s1_load     = !s1_vld_r || s2_load;
  assign in_ch.ready = s1_load;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (s1_load) begin
      s1_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load && in_ch.valid) begin
      s1_data_r <= in_ch.sample_in;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s2_load) begin
      out_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load && s1_vld_r) begin
      out_data_r <= conv;
    end
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.sample_out = out_data_r;

  // A word in the input register moves to the result register when it can
  a_s1_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && s2_load |=> out_vld_r)
    else $error("input word lost on its way to the result register");

  // Reset empties the input and result registers
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_vld_r && !s1_vld_r)
    else $error("pipeline not empty after reset");

  // Unassigned format codes give a zero result
  a_bad_fmt_zero: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && s2_load && (cfg.in_fmt > asfc_pkg::FMT_DBL ||
                            cfg.out_fmt > asfc_pkg::FMT_DBL)
    |=> out_data_r == 64'd0)
    else $error("nonzero result for an unassigned format code");

  // A u8 result keeps its upper bits clear
  a_u8_width: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && s2_load && cfg.out_fmt == asfc_pkg::FMT_U8
    |=> out_data_r[63:8] == 56'd0)
    else $error("u8 result has bits above its width");

endmodule

`default_nettype wire

### sv/asfc_cfg.sv
// APB-style register file holding the input and output format codes.
// Depends on asfc_pkg.
`default_nettype none

module asfc_cfg (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [2:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output asfc_pkg::fmt_cfg_t    cfg
);

  asfc_pkg::fmt_t in_fmt_r;
  asfc_pkg::fmt_t out_fmt_r;
  logic           wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Write the addressed format register in the access cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_fmt_r  <= asfc_pkg::FMT_U8;
      out_fmt_r <= asfc_pkg::FMT_U8;
    end else if (wr_en) begin
      case (paddr[2])
        asfc_pkg::REG_IN_FMT:  in_fmt_r  <= pwdata[2:0];
        asfc_pkg::REG_OUT_FMT: out_fmt_r <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (paddr[2])
      asfc_pkg::REG_IN_FMT:  prdata = {29'd0, in_fmt_r};
      asfc_pkg::REG_OUT_FMT: prdata = {29'd0, out_fmt_r};
      default:               prdata = 32'd0;
    endcase
  end

  assign cfg.in_fmt  = in_fmt_r;
  assign cfg.out_fmt = out_fmt_r;

endmodule

`default_nettype wire

### sv/asfc_unpack.sv
// Unpacks a raw sample of any format into sign, class, exponent and
// normalized fraction, plus the signed integer value. Depends on asfc_pkg.
`default_nettype none

module asfc_unpack (
  input  wire asfc_pkg::fmt_t fi,
  input  wire logic [63:0]    raw,
  output asfc_pkg::unp_t      unp
);

  logic signed [32:0] ival;
  logic [32:0]        mag33;
  logic [31:0]        mag;
  logic [4:0]         lz_i;
  logic [31:0]        norm_i;
  logic [4:0]         wm1;
  logic [7:0]         fex;
  logic [22:0]        ffr;
  logic [4:0]         lz_f;
  logic [22:0]        norm_f;
  logic [10:0]        dex;
  logic [51:0]        dfr;

  // Signed integer value, u8 offset removed
  always_comb begin
    case (fi)
      asfc_pkg::FMT_U8:  ival = $signed({25'd0, raw[7:0]}) - 33'sd128;
      asfc_pkg::FMT_S16: ival = $signed({{17{raw[15]}}, raw[15:0]});
      default:           ival = $signed({raw[31], raw[31:0]});
    endcase
  end

  // Normalize integer magnitude
  assign mag33  = ival[32] ? 33'(-ival) : 33'(ival);
  assign mag    = mag33[31:0];
  assign lz_i   = asfc_pkg::lzc32(mag);
  assign norm_i = mag << lz_i;
  assign wm1    = asfc_pkg::int_wm1(fi);

  // Float fields and subnormal normalization
  assign fex    = raw[30:23];
  assign ffr    = raw[22:0];
  assign lz_f   = asfc_pkg::lzc32({ffr, 9'd0});
  assign norm_f = ffr << lz_f;

  assign dex = raw[62:52];
  assign dfr = raw[51:0];

  // Classify and build the unpacked value
  always_comb begin
    unp.ival = ival;
    unp.cls  = asfc_pkg::CLS_ZERO;
    unp.sign = 1'b0;
    unp.expo = 13'sd0;
    unp.frac = 52'd0;
    case (fi)
      asfc_pkg::FMT_U8, asfc_pkg::FMT_S16, asfc_pkg::FMT_S32: begin
        unp.sign = ival[32];
        unp.cls  = (mag == 32'd0) ? asfc_pkg::CLS_ZERO : asfc_pkg::CLS_NUM;
        unp.expo = $signed({8'd0, 5'd31 - lz_i}) - $signed({8'd0, wm1});
        unp.frac = {norm_i[30:0], 21'd0};
      end
      asfc_pkg::FMT_FLT: begin
        unp.sign = raw[31];
        unp.frac = {ffr, 29'd0};
        if (fex == 8'hff) begin
          unp.cls = (ffr != 23'd0) ? asfc_pkg::CLS_NAN : asfc_pkg::CLS_INF;
        end else if (fex == 8'd0) begin
          unp.cls  = (ffr == 23'd0) ? asfc_pkg::CLS_ZERO : asfc_pkg::CLS_NUM;
          unp.expo = -13'sd127 - $signed({8'd0, lz_f});
          unp.frac = {norm_f[21:0], 30'd0};
        end else begin
          unp.cls  = asfc_pkg::CLS_NUM;
          unp.expo = $signed({5'd0, fex}) - 13'sd127;
        end
      end
      asfc_pkg::FMT_DBL: begin
        unp.sign = raw[63];
        unp.frac = dfr;
        if (dex == 11'h7ff) begin
          unp.cls = (dfr != 52'd0) ? asfc_pkg::CLS_NAN : asfc_pkg::CLS_INF;
        end else if (dex == 11'd0) begin
          // Subnormal doubles lie far below any float or integer step
          unp.cls  = (dfr == 52'd0) ? asfc_pkg::CLS_ZERO : asfc_pkg::CLS_NUM;
          unp.expo = -13'sd1074;
          unp.frac = 52'd0;
        end else begin
          unp.cls  = asfc_pkg::CLS_NUM;
          unp.expo = $signed({2'd0, dex}) - 13'sd1023;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

### sv/asfc_pack.sv
// Packs an unpacked sample into the output format with round to nearest
// even and saturation; also the integer-to-integer path. Depends on asfc_pkg.
`default_nettype none

module asfc_pack (
  input  wire asfc_pkg::fmt_cfg_t cfg,
  input  wire logic [63:0]        raw,
  input  wire asfc_pkg::unp_t     unp,
  output logic [63:0]             res
);

  logic [52:0]        sig;
  logic [4:0]         wi_m1;
  logic [4:0]         wo_m1;
  // integer to integer
  logic signed [32:0] iv;
  // double result
  logic [12:0]        dexp;
  logic [63:0]        dres;
  // float result
  logic signed [12:0] fbias;
  logic signed [12:0] fsh;
  logic               f_norm;
  logic [5:0]         ftot;
  logic [116:0]       fwide;
  logic [30:0]        fbase;
  logic               fround;
  logic [30:0]        frnd;
  logic [31:0]        fres;
  // float to integer
  logic signed [12:0] isr;
  logic [5:0]         isr_c;
  logic [116:0]       iwide;
  logic [31:0]        iq;
  logic [31:0]        iqr;
  logic [31:0]        half;
  logic [31:0]        ires;

  assign sig   = {1'b1, unp.frac};
  assign wi_m1 = asfc_pkg::int_wm1(cfg.in_fmt);
  assign wo_m1 = asfc_pkg::int_wm1(cfg.out_fmt);

  // Integer widening shifts left, narrowing floors
  assign iv = (wo_m1 > wi_m1) ? (unp.ival <<< (wo_m1 - wi_m1))
                              : (unp.ival >>> (wi_m1 - wo_m1));

  // Double: exact from any narrower source
  assign dexp = unp.expo + 13'sd1023;
  always_comb begin
    case (unp.cls)
      asfc_pkg::CLS_ZERO: dres = {unp.sign, 63'd0};
      asfc_pkg::CLS_INF:  dres = {unp.sign, 11'h7ff, 52'd0};
      asfc_pkg::CLS_NAN:  dres = {unp.sign, 11'h7ff, 1'b1, unp.frac[50:0]};
      default:            dres = {unp.sign, dexp[10:0], unp.frac};
    endcase
  end

  // Float: align to normal or subnormal position, then round
  assign fbias  = unp.expo + 13'sd127;
  assign fsh    = -13'sd126 - unp.expo;
  assign f_norm = (unp.expo >= -13'sd126);
  assign ftot   = f_norm ? 6'd29 : ((fsh > 13'sd31) ? 6'd60 : 6'(fsh[5:0] + 6'd29));
  assign fwide  = {sig, 64'd0} >> ftot;
  assign fbase  = f_norm ? {fbias[7:0], fwide[86:64]} : {8'd0, fwide[86:64]};
  assign fround = fwide[63] && ((|fwide[62:0]) || fbase[0]);
  // Mantissa carry walks into the exponent, reaching infinity at the top
  assign frnd   = fbase + {30'd0, fround};
  always_comb begin
    case (unp.cls)
      asfc_pkg::CLS_ZERO: fres = {unp.sign, 31'd0};
      asfc_pkg::CLS_INF:  fres = {unp.sign, 8'hff, 23'd0};
      asfc_pkg::CLS_NAN:  fres = {unp.sign, 8'hff, 1'b1, unp.frac[50:29]};
      default: begin
        if (unp.expo > 13'sd127) begin
          fres = {unp.sign, 8'hff, 23'd0};
        end else begin
          fres = {unp.sign, frnd};
        end
      end
    endcase
  end

  // Float to integer: scale by full scale, round, saturate
  assign isr   = 13'sd52 - unp.expo - $signed({8'd0, wo_m1});
  assign isr_c = (isr > 13'sd63) ? 6'd63 : isr[5:0];
  assign iwide = {sig, 64'd0} >> isr_c;
  assign iq    = iwide[95:64];
  assign iqr   = iq + {31'd0, iwide[63] && ((|iwide[62:0]) || iq[0])};
  assign half  = 32'd1 << wo_m1;
  always_comb begin
    case (unp.cls)
      asfc_pkg::CLS_NUM: begin
        if (unp.expo >= 13'sd0 || (!unp.sign && iqr >= half)) begin
          ires = unp.sign ? (32'd0 - half) : (half - 32'd1);
        end else begin
          ires = unp.sign ? (32'd0 - iqr) : iqr;
        end
      end
      asfc_pkg::CLS_INF: ires = unp.sign ? (32'd0 - half) : (half - 32'd1);
      default:           ires = 32'd0;
    endcase
  end

  // Select the path for this pair of formats
  always_comb begin
    if (cfg.in_fmt > asfc_pkg::FMT_DBL || cfg.out_fmt > asfc_pkg::FMT_DBL) begin
      res = 64'd0;
    end else if (cfg.in_fmt == cfg.out_fmt) begin
      res = raw & asfc_pkg::fmt_mask(cfg.in_fmt);
    end else if (cfg.out_fmt == asfc_pkg::FMT_DBL) begin
      res = dres;
    end else if (cfg.out_fmt == asfc_pkg::FMT_FLT) begin
      res = {32'd0, fres};
    end else if (cfg.in_fmt <= asfc_pkg::FMT_S32) begin
      res = asfc_pkg::int_pack(cfg.out_fmt, iv[31:0]);
    end else begin
      res = asfc_pkg::int_pack(cfg.out_fmt, ires);
    end
  end

endmodule

`default_nettype wire
